FILE: rtl/bbn_pkg.sv
`timescale 1ns / 1ps

package bbn_pkg;

	localparam int COORD_W    = 32;
	localparam int TGT_W      = 31;
	localparam int OP_W       = 2;
	localparam int STAT_W     = 2;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;
	localparam int SCALE_W    = 32;
	// |2p - (min + max)| never exceeds 2^33
	localparam int MAG_W      = 34;
	// low slice of the magnitude that goes through the multiplier in one pass
	localparam int MUL_W      = 32;

	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic [SCALE_W-1:0]        scale_t;
	typedef logic [MAG_W-1:0]          mag_t;

	localparam logic [OP_W-1:0] OP_CLEAR     = OP_W'(0);
	localparam logic [OP_W-1:0] OP_MEASURE   = OP_W'(1);
	localparam logic [OP_W-1:0] OP_TRANSFORM = OP_W'(2);

	localparam logic [STAT_W-1:0] STAT_OK    = STAT_W'(0);
	localparam logic [STAT_W-1:0] STAT_DEGEN = STAT_W'(1);
	localparam logic [STAT_W-1:0] STAT_SAT   = STAT_W'(2);

	localparam logic [CFG_IDX_W-1:0] CFG_TARGET = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_OFF_X  = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] CFG_OFF_Y  = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] CFG_OFF_Z  = CFG_IDX_W'(3);

endpackage

FILE: rtl/bbn_div.sv
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per cycle. Quotient saturates to QUO_W bits.
module bbn_div #(
	parameter int NUM_W = 47,
	parameter int DEN_W = 32,
	parameter int QUO_W = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic             done,
	output logic [QUO_W-1:0] quo
);

	localparam int CNT_W = $clog2(NUM_W + 1);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [NUM_W-1:0] num_q;
	logic [NUM_W-1:0] quo_q;
	logic [DEN_W-1:0] den_q;
	logic [DEN_W-1:0] rem_q;
	logic [DEN_W:0]   shifted;
	logic [DEN_W:0]   trial;
	logic             ge;

	assign shifted = {rem_q, num_q[NUM_W-1]};
	assign trial   = shifted - {1'b0, den_q};
	assign ge      = !trial[DEN_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			num_q  <= '0;
			quo_q  <= '0;
			den_q  <= '0;
			rem_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start && !busy_q) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(NUM_W);
				num_q  <= num;
				den_q  <= den;
				rem_q  <= '0;
				quo_q  <= '0;
			end else if (busy_q) begin
				rem_q <= ge ? trial[DEN_W-1:0] : shifted[DEN_W-1:0];
				num_q <= num_q << 1;
				quo_q <= {quo_q[NUM_W-2:0], ge};
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done = done_q;
	assign quo  = (|quo_q[NUM_W-1:QUO_W]) ? '1 : quo_q[QUO_W-1:0];

endmodule

FILE: rtl/bbn_smul.sv
`timescale 1ns / 1ps

// Rounded magnitude * scale / 2^(FRAC_BITS+1), capped at 2^33.
// One 32x32 multiplier takes the low and the high slice of the magnitude in turn.
module bbn_smul #(
	parameter int FRAC_BITS = 16
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  bbn_pkg::mag_t   mag,
	input  bbn_pkg::scale_t scale,
	output logic            done,
	output bbn_pkg::mag_t   prod
);

	import bbn_pkg::*;

	localparam int HI_W  = MAG_W - MUL_W;
	localparam int P_W   = MUL_W + SCALE_W;
	localparam int PH_W  = HI_W + SCALE_W;
	localparam int SUM_W = PH_W + MUL_W + 1;
	localparam int SH    = FRAC_BITS + 1;
	localparam logic [SUM_W-1:0] HALF = SUM_W'(1) << (SH - 1);
	localparam logic [SUM_W-1:0] CAP  = SUM_W'(1) << (MAG_W - 1);

	typedef enum logic [1:0] {
		M_IDLE,
		M_HI,
		M_RND
	} mstate_t;

	mstate_t         state_q;
	logic [P_W-1:0]  plo_q;
	logic [PH_W-1:0] phi_q;
	mag_t            prod_q;
	logic            done_q;

	logic [MUL_W-1:0] mul_a;
	logic [P_W-1:0]   mul_p;
	logic [SUM_W-1:0] sum;
	logic [SUM_W-1:0] shr;

	assign mul_a = (state_q == M_HI) ? MUL_W'(mag[MAG_W-1:MUL_W]) : mag[MUL_W-1:0];
	assign mul_p = P_W'(mul_a) * P_W'(scale);
	assign sum   = {1'b0, phi_q, {MUL_W{1'b0}}} + SUM_W'(plo_q) + HALF;
	assign shr   = sum >> SH;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= M_IDLE;
			plo_q   <= '0;
			phi_q   <= '0;
			prod_q  <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				M_IDLE: begin
					if (start) begin
						plo_q   <= mul_p;
						state_q <= M_HI;
					end
				end
				M_HI: begin
					phi_q   <= mul_p[PH_W-1:0];
					state_q <= M_RND;
				end
				M_RND: begin
					prod_q  <= (shr > CAP) ? CAP[MAG_W-1:0] : shr[MAG_W-1:0];
					done_q  <= 1'b1;
					state_q <= M_IDLE;
				end
				default: state_q <= M_IDLE;
			endcase
		end
	end

	assign done = done_q;
	assign prod = prod_q;

endmodule

FILE: rtl/bounding_box_normalizer_top.sv
`timescale 1ns / 1ps
// Clear and measure are handled in the idle state, which stays ready for the next item.
// A transform with a cached scale runs 3 extent steps, then each axis in turn
// (S_AX_D, S_AX_ABS, S_AX_MUL, S_AX_WAIT, S_AX_OUT) through the shared multiplier.
// A transform after clear, measure or a target_size write first runs the bit-serial
// scale divide unless the box is degenerate. One item at a time; a result waits in
// the output register while the next request is taken. Reset empties the box.
module bounding_box_normalizer_top #(
	parameter int FRAC_BITS = 16
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   item_valid,
	output logic                                   item_ready,
	input  logic [bbn_pkg::OP_W-1:0]               op,
	input  bbn_pkg::coord_t                        px,
	input  bbn_pkg::coord_t                        py,
	input  bbn_pkg::coord_t                        pz,
	output logic                                   res_valid,
	input  logic                                   res_ready,
	output bbn_pkg::coord_t                        qx,
	output bbn_pkg::coord_t                        qy,
	output bbn_pkg::coord_t                        qz,
	output logic [bbn_pkg::STAT_W-1:0]             status,
	input  logic                                   cfg_valid,
	output logic                                   cfg_ready,
	input  logic [bbn_pkg::CFG_IDX_W-1:0]          cfg_index,
	input  logic [bbn_pkg::CFG_DATA_W-1:0]         cfg_data
);

	import bbn_pkg::*;

	localparam int NUM_W = TGT_W + FRAC_BITS;
	localparam int E_W   = COORD_W + 1;
	localparam int D_W   = COORD_W + 3;
	localparam int V_W   = COORD_W + 4;
	localparam logic [1:0] AX_LAST = 2'd2;
	localparam logic signed [V_W-1:0] VMAX = V_W'(2147483647);
	localparam logic signed [V_W-1:0] VMIN = -VMAX - V_W'(1);
	localparam coord_t POS_MAX = {1'b0, {(COORD_W-1){1'b1}}};
	localparam coord_t NEG_MAX = {1'b1, {(COORD_W-1){1'b0}}};

	typedef enum logic [3:0] {
		S_IDLE,
		S_EXT,
		S_CHECK,
		S_DIV_GO,
		S_DIV_WAIT,
		S_AX_D,
		S_AX_ABS,
		S_AX_MUL,
		S_AX_WAIT,
		S_AX_OUT,
		S_DONE
	} state_t;

	state_t                 state_q;
	coord_t                 min_q [3];
	coord_t                 max_q [3];
	coord_t                 off_q [3];
	coord_t                 p_q [3];
	coord_t                 work_q [3];
	coord_t                 res_q [3];
	logic [TGT_W-1:0]       target_q;
	scale_t                 scale_q;
	logic                   scale_ready_q;
	logic [1:0]             axis_q;
	logic signed [E_W-1:0]  big_q;
	logic signed [D_W-1:0]  d_q;
	mag_t                   mag_q;
	logic                   neg_q;
	logic                   sat_q;
	logic                   degen_q;
	logic                   res_valid_q;
	logic [STAT_W-1:0]      status_q;

	logic signed [E_W-1:0]  ext;
	logic signed [D_W-1:0]  d_c;
	logic signed [V_W-1:0]  m_ext;
	logic signed [V_W-1:0]  v_c;
	logic                   div_done;
	scale_t                 div_quo;
	logic                   smul_done;
	mag_t                   smul_prod;
	logic                   res_free;

	assign ext   = {max_q[axis_q][COORD_W-1], max_q[axis_q]}
	             - {min_q[axis_q][COORD_W-1], min_q[axis_q]};
	// doubled distance from the box center: 2p - (min + max)
	assign d_c   = (D_W'(p_q[axis_q]) <<< 1) - D_W'(min_q[axis_q]) - D_W'(max_q[axis_q]);
	assign m_ext = V_W'(smul_prod);
	assign v_c   = V_W'(off_q[axis_q]) + (neg_q ? -m_ext : m_ext);
	assign res_free = !res_valid_q || res_ready;

	bbn_div #(
		.NUM_W(NUM_W),
		.DEN_W(COORD_W),
		.QUO_W(SCALE_W)
	) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (state_q == S_DIV_GO),
		.num   ({target_q, {FRAC_BITS{1'b0}}}),
		.den   (big_q[COORD_W-1:0]),
		.done  (div_done),
		.quo   (div_quo)
	);

	bbn_smul #(
		.FRAC_BITS(FRAC_BITS)
	) u_smul (
		.clk   (clk),
		.arst_n(arst_n),
		.start (state_q == S_AX_MUL),
		.mag   (mag_q),
		.scale (scale_q),
		.done  (smul_done),
		.prod  (smul_prod)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			for (int i = 0; i < 3; i++) begin
				min_q[i]  <= POS_MAX;
				max_q[i]  <= NEG_MAX;
				off_q[i]  <= '0;
				p_q[i]    <= '0;
				work_q[i] <= '0;
				res_q[i]  <= '0;
			end
			target_q      <= TGT_W'(131072);
			scale_q       <= '0;
			scale_ready_q <= 1'b0;
			axis_q        <= '0;
			big_q         <= '0;
			d_q           <= '0;
			mag_q         <= '0;
			neg_q         <= 1'b0;
			sat_q         <= 1'b0;
			degen_q       <= 1'b0;
			res_valid_q   <= 1'b0;
			status_q      <= STAT_OK;
		end else begin
			// in S_DONE the output register is reloaded below instead
			if (res_valid_q && res_ready && state_q != S_DONE) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (item_valid) begin
						case (op)
							OP_CLEAR: begin
								for (int i = 0; i < 3; i++) begin
									min_q[i] <= POS_MAX;
									max_q[i] <= NEG_MAX;
								end
								scale_ready_q <= 1'b0;
							end
							OP_MEASURE: begin
								if (px < min_q[0]) min_q[0] <= px;
								if (py < min_q[1]) min_q[1] <= py;
								if (pz < min_q[2]) min_q[2] <= pz;
								if (px > max_q[0]) max_q[0] <= px;
								if (py > max_q[1]) max_q[1] <= py;
								if (pz > max_q[2]) max_q[2] <= pz;
								scale_ready_q <= 1'b0;
							end
							OP_TRANSFORM: begin
								p_q[0]  <= px;
								p_q[1]  <= py;
								p_q[2]  <= pz;
								axis_q  <= '0;
								sat_q   <= 1'b0;
								degen_q <= 1'b0;
								state_q <= S_EXT;
							end
							default: ;
						endcase
					end
				end
				S_EXT: begin
					if (axis_q == '0 || ext > big_q) begin
						big_q <= ext;
					end
					if (axis_q == AX_LAST) begin
						axis_q  <= '0;
						state_q <= S_CHECK;
					end else begin
						axis_q <= axis_q + 2'd1;
					end
				end
				S_CHECK: begin
					if (big_q[E_W-1] || big_q == '0) begin
						// empty box or all points equal: pass offsets through
						for (int i = 0; i < 3; i++) begin
							work_q[i] <= off_q[i];
						end
						degen_q <= 1'b1;
						state_q <= S_DONE;
					end else if (!scale_ready_q) begin
						state_q <= S_DIV_GO;
					end else begin
						state_q <= S_AX_D;
					end
				end
				S_DIV_GO: state_q <= S_DIV_WAIT;
				S_DIV_WAIT: begin
					if (div_done) begin
						scale_q       <= div_quo;
						scale_ready_q <= 1'b1;
						state_q       <= S_AX_D;
					end
				end
				S_AX_D: begin
					d_q     <= d_c;
					state_q <= S_AX_ABS;
				end
				S_AX_ABS: begin
					mag_q   <= d_q[D_W-1] ? MAG_W'(-d_q) : MAG_W'(d_q);
					neg_q   <= d_q[D_W-1];
					state_q <= S_AX_MUL;
				end
				S_AX_MUL: state_q <= S_AX_WAIT;
				S_AX_WAIT: begin
					if (smul_done) begin
						state_q <= S_AX_OUT;
					end
				end
				S_AX_OUT: begin
					if (v_c > VMAX) begin
						work_q[axis_q] <= POS_MAX;
						sat_q          <= 1'b1;
					end else if (v_c < VMIN) begin
						work_q[axis_q] <= NEG_MAX;
						sat_q          <= 1'b1;
					end else begin
						work_q[axis_q] <= v_c[COORD_W-1:0];
					end
					if (axis_q == AX_LAST) begin
						state_q <= S_DONE;
					end else begin
						axis_q  <= axis_q + 2'd1;
						state_q <= S_AX_D;
					end
				end
				S_DONE: begin
					if (res_free) begin
						for (int i = 0; i < 3; i++) begin
							res_q[i] <= work_q[i];
						end
						if (degen_q) begin
							status_q <= STAT_DEGEN;
						end else if (sat_q || scale_q == '1) begin
							status_q <= STAT_SAT;
						end else begin
							status_q <= STAT_OK;
						end
						res_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase

			if (cfg_valid) begin
				case (cfg_index)
					CFG_TARGET: begin
						target_q      <= cfg_data[TGT_W-1:0];
						scale_ready_q <= 1'b0;
					end
					CFG_OFF_X: off_q[0] <= cfg_data;
					CFG_OFF_Y: off_q[1] <= cfg_data;
					CFG_OFF_Z: off_q[2] <= cfg_data;
					default: ;
				endcase
			end
		end
	end

	assign item_ready = (state_q == S_IDLE);
	assign cfg_ready  = 1'b1;
	assign res_valid  = res_valid_q;
	assign qx         = res_q[0];
	assign qy         = res_q[1];
	assign qz         = res_q[2];
	assign status     = status_q;

	a_div_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == S_DIV_WAIT)
		else $error("divider finished outside its wait state");

	a_smul_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		smul_done |-> state_q == S_AX_WAIT)
		else $error("scaler finished outside its wait state");

	a_done_loads_result: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE && res_free) |=> res_valid_q && item_ready)
		else $error("finished transform did not post a result");

endmodule
